[design/hrbd_pkg.sv]
// Shared types, constants and helper functions of the HTTP response body deframer.
package hrbd_pkg;

  // Default width of the length and chunk size counters
  localparam int COUNT_WIDTH_DEF = 32;

  // Header patterns, right-aligned in a vector sized for the longest one
  localparam int PAT_CHARS = 27;
  localparam int PAT_BITS  = PAT_CHARS * 8;
  localparam logic [PAT_BITS-1:0] TERM_PAT = "\r\n\r\n";
  localparam logic [PAT_BITS-1:0] LEN_PAT  = "\nContent-Length: ";
  localparam logic [PAT_BITS-1:0] CHK_PAT  = "\nTransfer-Encoding: chunked";
  localparam logic [4:0] TERM_PAT_LEN = 5'd4;
  localparam logic [4:0] LEN_PAT_LEN  = 5'd17;
  localparam logic [4:0] CHK_PAT_LEN  = 5'd27;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_LENGTH  = 2'd0,
    MODE_CHUNKED = 2'd1,
    MODE_CLOSE   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CK_DIGITS = 2'd0,
    CK_LINE   = 2'd1,
    CK_DATA   = 2'd2,
    CK_TRAIL  = 2'd3
  } chunk_t;

  typedef enum logic [1:0] {
    END_LENGTH  = 2'd0,
    END_CHUNKED = 2'd1,
    END_CLOSE   = 2'd2,
    END_EARLY   = 2'd3
  } end_status_t;

  // Header scan results for the byte being processed
  typedef struct packed {
    logic term_hit;
    logic length_found;
    logic chunked_found;
  } hdr_info_t;

  // One result item
  typedef struct packed {
    logic        valid;
    logic [7:0]  payload;
    logic        payload_valid;
    logic        finished;
    end_status_t end_status;
    mode_t       body_mode;
  } res_t;

  // Step a pattern matcher by one byte; pos counts matched characters
  function automatic logic [4:0] advance_match(logic [4:0] pos, logic [4:0] plen,
                                               logic [PAT_BITS-1:0] pat, logic [7:0] b);
    logic [4:0] sel;
    logic [4:0] first;
    logic [7:0] pc;
    logic [7:0] p0;
    sel   = (pos < plen) ? (plen - 5'd1 - pos) : 5'd0;
    first = plen - 5'd1;
    pc    = pat[{sel, 3'b000} +: 8];
    p0    = pat[{first, 3'b000} +: 8];
    if (pos < plen && b == pc) begin
      return pos + 5'd1;
    end
    return (b == p0) ? 5'd1 : 5'd0;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b >= "0" && b <= "9") begin
      t = b - "0";
      return {1'b1, t[3:0]};
    end
    if (b >= "a" && b <= "f") begin
      t = b - "a" + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (b >= "A" && b <= "F") begin
      t = b - "A" + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

[design/http_response_body_deframer.sv]
// Top level of the HTTP response body deframer: input register, scan and body logic, result register.
// Takes one response byte (or a connection-closed event) per cycle and returns the body bytes,
// each with the body mode, and one finishing result that carries the end status. A byte is
// registered in the input register on transfer, processed by the header scanner and body tracker and
// loaded into the result register once it can take the result; one item is taken every cycle while
// the result side keeps up. Header bytes,
// chunk size lines and the two bytes after each chunk produce no result. After the finishing
// result all further input is taken and dropped. COUNT_WIDTH sets the width of the length and
// chunk counters, which saturate.
module http_response_body_deframer #(
  parameter int COUNT_WIDTH = hrbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload,
  output logic       out_payload_valid,
  output logic       out_finished,
  output logic [1:0] out_end_status,
  output logic [1:0] out_body_mode
);
  import hrbd_pkg::*;

  logic                   s1_valid_r;
  logic                   s1_kind_r;
  logic [7:0]             s1_byte_r;
  logic                   step;
  logic                   in_header;
  logic                   hdr_en;
  hdr_info_t              hdr;
  logic [COUNT_WIDTH-1:0] declared_nxt;
  res_t                   res;
  res_t                   out_r;

  // Process the registered item when the result register can take its result
  assign step     = s1_valid_r && (!out_r.valid || !out_stall);
  assign in_stall = s1_valid_r && !step;
  assign hdr_en   = step && in_header && !s1_kind_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_data_byte;
    end
  end

  hrbd_hdr_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_hdr_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (hdr_en),
    .data_byte   (s1_byte_r),
    .info        (hdr),
    .declared_nxt(declared_nxt)
  );

  hrbd_body #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_body (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .kind        (s1_kind_r),
    .data_byte   (s1_byte_r),
    .hdr         (hdr),
    .declared_nxt(declared_nxt),
    .in_header   (in_header),
    .res         (res)
  );

  // Result register: load on step, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (step) begin
      out_r <= res;
    end else if (!out_stall) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_valid         = out_r.valid;
  assign out_payload       = out_r.payload;
  assign out_payload_valid = out_r.payload_valid;
  assign out_finished      = out_r.finished;
  assign out_end_status    = out_r.end_status;
  assign out_body_mode     = out_r.body_mode;

  // Every result carries a byte or finishes the response
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload_valid || out_finished))
    else $error("result with neither payload nor finish");

  // A non-finishing result reports length status
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_finished) |-> (out_end_status == END_LENGTH))
    else $error("end status set on a non-finishing result");

  // Stall only while an item waits in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A new result loaded while stalled would lose the held one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_payload) && $stable(out_finished)))
    else $error("held result changed under stall");

endmodule

[design/hrbd_hdr_scan.sv]
// Header scanner: pattern matchers for the header end, Content-Length and chunked encoding.
module hrbd_hdr_scan #(
  parameter int COUNT_WIDTH = hrbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [7:0]             data_byte,
  output hrbd_pkg::hdr_info_t    info,
  output logic [COUNT_WIDTH-1:0] declared_nxt
);
  import hrbd_pkg::*;

  logic [1:0]             term_match_r, term_match_nxt;
  logic [4:0]             len_match_r, len_match_nxt;
  logic [4:0]             chk_match_r, chk_match_nxt;
  logic                   digits_active_r, digits_active_nxt;
  logic                   length_found_r, length_found_nxt;
  logic                   chunked_found_r, chunked_found_nxt;
  logic [COUNT_WIDTH-1:0] declared_r;

  logic [4:0]             term_m, len_m, chk_m;
  logic                   is_digit;
  logic [COUNT_WIDTH+3:0] dec_ext, dec_sum;
  logic [COUNT_WIDTH-1:0] dec_sat;

  // Matchers for the current byte
  assign term_m = advance_match({3'b000, term_match_r}, TERM_PAT_LEN, TERM_PAT, data_byte);
  assign len_m  = advance_match(len_match_r, LEN_PAT_LEN, LEN_PAT, data_byte);
  assign chk_m  = advance_match(chk_match_r, CHK_PAT_LEN, CHK_PAT, data_byte);

  // Decimal accumulate with saturation: v*10 + d
  assign is_digit = (data_byte >= "0") && (data_byte <= "9");
  assign dec_ext  = {4'b0000, declared_r};
  assign dec_sum  = (dec_ext << 3) + (dec_ext << 1) + (COUNT_WIDTH+4)'(data_byte[3:0]);
  assign dec_sat  = (|dec_sum[COUNT_WIDTH+3:COUNT_WIDTH]) ? '1 : dec_sum[COUNT_WIDTH-1:0];

  // Next header scan state
  always_comb begin
    term_match_nxt    = term_match_r;
    len_match_nxt     = len_match_r;
    chk_match_nxt     = chk_match_r;
    digits_active_nxt = digits_active_r;
    length_found_nxt  = length_found_r;
    chunked_found_nxt = chunked_found_r;
    declared_nxt      = declared_r;
    info.term_hit     = 1'b0;
    if (en) begin
      if (digits_active_r) begin
        if (is_digit) begin
          declared_nxt = dec_sat;
        end else begin
          digits_active_nxt = 1'b0;
        end
      end
      if (!length_found_r) begin
        len_match_nxt = len_m;
        if (len_m == LEN_PAT_LEN) begin
          length_found_nxt  = 1'b1;
          digits_active_nxt = 1'b1;
          declared_nxt      = '0;
        end
      end
      if (!chunked_found_r) begin
        chk_match_nxt = chk_m;
        if (chk_m == CHK_PAT_LEN) begin
          chunked_found_nxt = 1'b1;
        end
      end
      if (term_m == TERM_PAT_LEN) begin
        info.term_hit     = 1'b1;
        term_match_nxt    = 2'd0;
        digits_active_nxt = 1'b0;
      end else begin
        term_match_nxt = term_m[1:0];
      end
    end
    info.length_found  = length_found_nxt;
    info.chunked_found = chunked_found_nxt;
  end

  // Hold scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_match_r    <= 2'd0;
      len_match_r     <= 5'd0;
      chk_match_r     <= 5'd0;
      digits_active_r <= 1'b0;
      length_found_r  <= 1'b0;
      chunked_found_r <= 1'b0;
      declared_r      <= '0;
    end else begin
      term_match_r    <= term_match_nxt;
      len_match_r     <= len_match_nxt;
      chk_match_r     <= chk_match_nxt;
      digits_active_r <= digits_active_nxt;
      length_found_r  <= length_found_nxt;
      chunked_found_r <= chunked_found_nxt;
      declared_r      <= declared_nxt;
    end
  end

endmodule

[design/hrbd_body.sv]
// Body tracker: phase, body mode, chunk parsing, byte counts and result formation.
module hrbd_body #(
  parameter int COUNT_WIDTH = hrbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   kind,
  input  logic [7:0]             data_byte,
  input  hrbd_pkg::hdr_info_t    hdr,
  input  logic [COUNT_WIDTH-1:0] declared_nxt,
  output logic                   in_header,
  output hrbd_pkg::res_t         res
);
  import hrbd_pkg::*;

  phase_t                 phase_r, phase_nxt;
  mode_t                  mode_r, mode_nxt;
  chunk_t                 chunk_r, chunk_nxt;
  logic                   cr_seen_r, cr_seen_nxt;
  logic [COUNT_WIDTH-1:0] bytes_left_r, bytes_left_nxt;

  logic [COUNT_WIDTH-1:0] bl_dec;
  logic                   bl_last;
  logic [4:0]             hex;
  logic [COUNT_WIDTH-1:0] hex_acc;
  logic                   is_cr, is_lf;

  assign in_header = (phase_r == PH_HEADER);
  assign bl_dec    = bytes_left_r - COUNT_WIDTH'(1);
  assign bl_last   = (bl_dec == '0);
  assign hex       = hex_val(data_byte);
  assign is_cr     = (data_byte == CHAR_CR);
  assign is_lf     = (data_byte == CHAR_LF);

  // Hex accumulate with saturation: v*16 + h
  assign hex_acc = (|bytes_left_r[COUNT_WIDTH-1 -: 4]) ? '1 :
                   {bytes_left_r[COUNT_WIDTH-5:0], hex[3:0]};

  // Next state
  always_comb begin
    phase_nxt      = phase_r;
    mode_nxt       = mode_r;
    chunk_nxt      = chunk_r;
    cr_seen_nxt    = cr_seen_r;
    bytes_left_nxt = bytes_left_r;
    if (step && phase_r != PH_DONE) begin
      if (kind) begin
        phase_nxt = PH_DONE;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hdr.term_hit) begin
              phase_nxt = PH_BODY;
              if (hdr.length_found) begin
                mode_nxt       = MODE_LENGTH;
                bytes_left_nxt = declared_nxt;
                if (declared_nxt == '0) begin
                  phase_nxt = PH_DONE;
                end
              end else if (hdr.chunked_found) begin
                mode_nxt       = MODE_CHUNKED;
                bytes_left_nxt = '0;
                chunk_nxt      = CK_DIGITS;
                cr_seen_nxt    = 1'b0;
              end else begin
                mode_nxt = MODE_CLOSE;
              end
            end
          end
          PH_BODY: begin
            if (mode_r == MODE_LENGTH) begin
              bytes_left_nxt = bl_dec;
              if (bl_last) begin
                phase_nxt = PH_DONE;
              end
            end else if (mode_r == MODE_CHUNKED) begin
              unique case (chunk_r)
                CK_DIGITS: begin
                  if (hex[4]) begin
                    bytes_left_nxt = hex_acc;
                  end else begin
                    chunk_nxt   = CK_LINE;
                    cr_seen_nxt = is_cr;
                  end
                end
                CK_LINE: begin
                  if (cr_seen_r && is_lf) begin
                    cr_seen_nxt = 1'b0;
                    if (bytes_left_r == '0) begin
                      phase_nxt = PH_DONE;
                    end else begin
                      chunk_nxt = CK_DATA;
                    end
                  end else begin
                    cr_seen_nxt = is_cr;
                  end
                end
                CK_DATA: begin
                  bytes_left_nxt = bl_dec;
                  if (bl_last) begin
                    chunk_nxt   = CK_TRAIL;
                    cr_seen_nxt = 1'b0;
                  end
                end
                CK_TRAIL: begin
                  if (!cr_seen_r) begin
                    cr_seen_nxt = 1'b1;
                  end else begin
                    cr_seen_nxt    = 1'b0;
                    chunk_nxt      = CK_DIGITS;
                    bytes_left_nxt = '0;
                  end
                end
              endcase
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result for the current item
  always_comb begin
    res            = '0;
    res.body_mode  = in_header ? MODE_LENGTH : mode_r;
    res.end_status = END_LENGTH;
    if (step && phase_r != PH_DONE) begin
      if (kind) begin
        res.valid      = 1'b1;
        res.finished   = 1'b1;
        res.end_status = (phase_r == PH_BODY && mode_r == MODE_CLOSE) ? END_CLOSE : END_EARLY;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hdr.term_hit && hdr.length_found && declared_nxt == '0) begin
              res.valid      = 1'b1;
              res.finished   = 1'b1;
              res.end_status = END_LENGTH;
            end
          end
          PH_BODY: begin
            if (mode_r == MODE_LENGTH) begin
              res.valid         = 1'b1;
              res.payload       = data_byte;
              res.payload_valid = 1'b1;
              res.finished      = bl_last;
            end else if (mode_r == MODE_CHUNKED) begin
              if (chunk_r == CK_DATA) begin
                res.valid         = 1'b1;
                res.payload       = data_byte;
                res.payload_valid = 1'b1;
              end else if (chunk_r == CK_LINE && cr_seen_r && is_lf &&
                           bytes_left_r == '0) begin
                res.valid      = 1'b1;
                res.finished   = 1'b1;
                res.end_status = END_CHUNKED;
              end
            end else begin
              res.valid         = 1'b1;
              res.payload       = data_byte;
              res.payload_valid = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Hold body state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      mode_r       <= MODE_LENGTH;
      chunk_r      <= CK_DIGITS;
      cr_seen_r    <= 1'b0;
      bytes_left_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      mode_r       <= mode_nxt;
      chunk_r      <= chunk_nxt;
      cr_seen_r    <= cr_seen_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule
